/* hw/rtl/dvc_pkg.sv */
package dvc_pkg;

    // Request on the input channel
    typedef struct packed {
        logic        command;
        logic [63:0] value;
    } dvc_in_t;

    // Result on the output channel
    typedef struct packed {
        logic [63:0] entry_value;
        logic [31:0] entry_count;
        logic [5:0]  entry_index;
        logic [2:0]  status;
        logic        last;
    } dvc_out_t;

    // Input command codes
    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_DUMP = 1'b1;

    // Result status codes
    localparam logic [2:0] ST_MATCH  = 3'd0;
    localparam logic [2:0] ST_INSERT = 3'd1;
    localparam logic [2:0] ST_FULL   = 3'd2;
    localparam logic [2:0] ST_DUMP   = 3'd3;
    localparam logic [2:0] ST_EMPTY  = 3'd4;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MATCH,
        S_NOMATCH,
        S_DUMP_RD,
        S_DUMP_OUT,
        S_EMPTY
    } dvc_state_t;

    // Kind of result the datapath loads into its output register
    typedef enum logic [2:0] {
        EMIT_NONE,
        EMIT_MATCH,
        EMIT_INSERT,
        EMIT_FULL,
        EMIT_DUMP,
        EMIT_EMPTY
    } dvc_emit_t;

    // Controller to datapath
    typedef struct packed {
        logic      load;
        logic      rd_en;
        dvc_emit_t emit;
    } dvc_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic used_zero;
        logic scan_done;
        logic cmp_valid;
        logic cmp_hit;
        logic cmp_last;
        logic out_free;
    } dvc_status_t;

endpackage

/* hw/rtl/distinct_value_counter.sv */
// Distinct value counter: keeps up to TABLE_DEPTH distinct doubles in order of
// first appearance, each with a saturating COUNT_BITS occurrence count. An add
// request scans the stored entries through the single read port of the table
// memory, one entry per cycle, and stops at the first match or after the last
// entry; its result then waits for a free output register. A dump request
// reads each stored entry and sends it, in order, waiting for a free output
// register before each send; a dump of an empty table sends one empty-status
// result. One request is worked at a time; the next is taken as soon as the
// previous result sits in the output register.
module distinct_value_counter #(
    parameter int TABLE_DEPTH = 64,
    parameter int COUNT_BITS  = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  dvc_pkg::dvc_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output dvc_pkg::dvc_out_t m_data
);
    import dvc_pkg::*;

    dvc_cmd_t    cmd;
    dvc_status_t stat;

    dvc_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .in_command (s_data.command),
        .stat       (stat),
        .cmd        (cmd)
    );

    dvc_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COUNT_BITS  (COUNT_BITS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

/* hw/rtl/dvc_ctrl.sv */
module dvc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                in_command,
    input  dvc_pkg::dvc_status_t stat,
    output dvc_pkg::dvc_cmd_t    cmd
);
    import dvc_pkg::*;

    dvc_state_t state_reg;
    dvc_state_t state_next;
    logic       accept;

    assign accept = s_valid && s_ready;

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (in_command == CMD_DUMP) begin
                        state_next = stat.used_zero ? S_EMPTY : S_DUMP_RD;
                    end else begin
                        state_next = stat.used_zero ? S_NOMATCH : S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (stat.cmp_valid && stat.cmp_hit) begin
                    state_next = S_MATCH;
                end else if (stat.cmp_valid && stat.cmp_last) begin
                    state_next = S_NOMATCH;
                end
            end
            S_MATCH, S_NOMATCH, S_EMPTY: begin
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_DUMP_RD: begin
                state_next = S_DUMP_OUT;
            end
            S_DUMP_OUT: begin
                if (stat.out_free) begin
                    state_next = stat.cmp_last ? S_IDLE : S_DUMP_RD;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        s_ready   = 1'b0;
        cmd.load  = 1'b0;
        cmd.rd_en = 1'b0;
        cmd.emit  = EMIT_NONE;
        case (state_reg)
            S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = accept;
            end
            S_SCAN: begin
                // stop issuing reads once a hit shows up
                cmd.rd_en = !stat.scan_done && !(stat.cmp_valid && stat.cmp_hit);
            end
            S_MATCH: begin
                if (stat.out_free) cmd.emit = EMIT_MATCH;
            end
            S_NOMATCH: begin
                // the datapath turns an insert into a drop when full
                if (stat.out_free) cmd.emit = EMIT_INSERT;
            end
            S_DUMP_RD: begin
                cmd.rd_en = 1'b1;
            end
            S_DUMP_OUT: begin
                if (stat.out_free) cmd.emit = EMIT_DUMP;
            end
            S_EMPTY: begin
                if (stat.out_free) cmd.emit = EMIT_EMPTY;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

/* hw/rtl/dvc_datapath.sv */
module dvc_datapath #(
    parameter int TABLE_DEPTH = 64,
    parameter int COUNT_BITS  = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dvc_pkg::dvc_in_t     s_data,
    input  dvc_pkg::dvc_cmd_t    cmd,
    output dvc_pkg::dvc_status_t stat,
    output logic                 m_valid,
    input  logic                 m_ready,
    output dvc_pkg::dvc_out_t    m_data
);
    import dvc_pkg::*;

    localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int USED_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [USED_W-1:0] DEPTH_U = USED_W'(TABLE_DEPTH);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    logic [63:0]         val_mem [TABLE_DEPTH];
    logic [COUNT_BITS-1:0] cnt_mem [TABLE_DEPTH];

    logic [63:0]           val_in_reg;
    logic [USED_W-1:0]     used_reg;
    logic [USED_W-1:0]     idx_reg;
    logic [IDX_W-1:0]      cmp_idx_reg;
    logic                  cmp_valid_reg;
    logic [63:0]           rd_val_reg;
    logic [COUNT_BITS-1:0] rd_cnt_reg;
    logic                  m_valid_reg;
    logic                  m_valid_next;
    dvc_out_t              m_data_reg;
    dvc_out_t              m_data_next;

    logic                  full;
    logic                  out_free;
    logic                  cmp_last;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic                  do_insert;
    logic                  do_match;

    // Double equality: NaN matches nothing, signed zeros match
    function automatic logic is_nan(input logic [63:0] b);
        return (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
    endfunction

    function automatic logic dbl_equal(input logic [63:0] a, input logic [63:0] b);
        logic res;
        if (is_nan(a) || is_nan(b)) begin
            res = 1'b0;
        end else if (((a | b) & 64'h7FFF_FFFF_FFFF_FFFF) == 64'd0) begin
            res = 1'b1;
        end else begin
            res = (a == b);
        end
        return res;
    endfunction

    // Clip a count to the 32-bit result field
    function automatic logic [31:0] clip_count(input logic [COUNT_BITS-1:0] c);
        logic [63:0] w;
        w = 64'(c);
        return (|w[63:32]) ? 32'hFFFF_FFFF : w[31:0];
    endfunction

    assign full      = (used_reg == DEPTH_U);
    assign out_free  = !m_valid_reg || m_ready;
    assign cmp_last  = (USED_W'(cmp_idx_reg) + USED_W'(1)) == used_reg;
    assign cnt_inc   = (rd_cnt_reg == CNT_MAX) ? rd_cnt_reg : rd_cnt_reg + COUNT_BITS'(1);
    assign do_insert = (cmd.emit == EMIT_INSERT) && !full;
    assign do_match  = (cmd.emit == EMIT_MATCH);

    assign stat.used_zero = (used_reg == '0);
    assign stat.scan_done = (idx_reg == used_reg);
    assign stat.cmp_valid = cmp_valid_reg;
    assign stat.cmp_hit   = dbl_equal(rd_val_reg, val_in_reg);
    assign stat.cmp_last  = cmp_last;
    assign stat.out_free  = out_free;

    // Value store: write on insert, registered read
    always_ff @(posedge aclk) begin
        if (do_insert) begin
            val_mem[used_reg[IDX_W-1:0]] <= val_in_reg;
        end
        if (cmd.rd_en) begin
            rd_val_reg <= val_mem[idx_reg[IDX_W-1:0]];
        end
    end

    // Count store: bump on match, seed on insert, registered read
    always_ff @(posedge aclk) begin
        if (do_match) begin
            cnt_mem[cmp_idx_reg] <= cnt_inc;
        end else if (do_insert) begin
            cnt_mem[used_reg[IDX_W-1:0]] <= COUNT_BITS'(1);
        end
        if (cmd.rd_en) begin
            rd_cnt_reg <= cnt_mem[idx_reg[IDX_W-1:0]];
        end
    end

    // Latch request value; tag each read with its index
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            val_in_reg <= s_data.value;
        end
        if (cmd.rd_en) begin
            cmp_idx_reg <= idx_reg[IDX_W-1:0];
        end
    end

    // Control registers: fill count, read pointer, read tag valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg      <= '0;
            idx_reg       <= '0;
            cmp_valid_reg <= 1'b0;
        end else begin
            cmp_valid_reg <= cmd.rd_en;
            if (cmd.load) begin
                idx_reg <= '0;
            end else if (cmd.rd_en) begin
                idx_reg <= idx_reg + USED_W'(1);
            end
            if (do_insert) begin
                used_reg <= used_reg + USED_W'(1);
            end
        end
    end

    // Build the next result
    always_comb begin
        m_data_next = m_data_reg;
        case (cmd.emit)
            EMIT_MATCH: begin
                m_data_next.entry_value = rd_val_reg;
                m_data_next.entry_count = clip_count(cnt_inc);
                m_data_next.entry_index = 6'(cmp_idx_reg);
                m_data_next.status      = ST_MATCH;
                m_data_next.last        = 1'b1;
            end
            EMIT_INSERT: begin
                m_data_next.entry_value = val_in_reg;
                m_data_next.entry_count = full ? 32'd0 : 32'd1;
                m_data_next.entry_index = full ? 6'd0 : 6'(used_reg);
                m_data_next.status      = full ? ST_FULL : ST_INSERT;
                m_data_next.last        = 1'b1;
            end
            EMIT_FULL: begin
                m_data_next.entry_value = val_in_reg;
                m_data_next.entry_count = 32'd0;
                m_data_next.entry_index = 6'd0;
                m_data_next.status      = ST_FULL;
                m_data_next.last        = 1'b1;
            end
            EMIT_DUMP: begin
                m_data_next.entry_value = rd_val_reg;
                m_data_next.entry_count = clip_count(rd_cnt_reg);
                m_data_next.entry_index = 6'(cmp_idx_reg);
                m_data_next.status      = ST_DUMP;
                m_data_next.last        = cmp_last;
            end
            EMIT_EMPTY: begin
                m_data_next.entry_value = 64'd0;
                m_data_next.entry_count = 32'd0;
                m_data_next.entry_index = 6'd0;
                m_data_next.status      = ST_EMPTY;
                m_data_next.last        = 1'b1;
            end
            default: begin
                m_data_next = m_data_reg;
            end
        endcase
    end

    // Output register: load on emit, drop when taken
    always_comb begin
        if (cmd.emit != EMIT_NONE) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A result is loaded only into a free output register
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit != EMIT_NONE) |-> out_free)
        else $error("result loaded over a pending one");

    // Fill count stays within the table
    a_used_range: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= DEPTH_U)
        else $error("fill count beyond table depth");

    // Reads only touch written entries
    a_rd_written: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_en |-> (idx_reg < used_reg))
        else $error("read of an unwritten entry");

    // A match result shows the match status and a nonzero count
    a_match_count: assert property (@(posedge aclk) disable iff (!aresetn)
        do_match |=> (m_data_reg.status == ST_MATCH) && (m_data_reg.entry_count != 32'd0))
        else $error("match result without a count");

endmodule
